/* design/cidq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidq_pkg
// Shared types, widths and constants of the cell-ID quality checker.
// ----------------------------------------------------------------------------
package cidq_pkg;

    // Default geometry
    localparam int ARMS_DEF       = 2;
    localparam int PACKETS_DEF    = 8;
    localparam int CHIPS_DEF      = 48;
    localparam int GROUP_SIZE_DEF = 12;

    // Field widths
    localparam int VALUE_BITS  = 8;
    localparam int ARM_BITS    = 1;
    localparam int PACKET_BITS = 3;
    localparam int CHIP_BITS   = 6;
    localparam int RUN_BITS    = 3;
    localparam int MASK_BITS   = 12;
    localparam int LIMIT_BITS  = 8;
    localparam int WINDOW_BITS = 3;

    localparam logic [RUN_BITS-1:0] RUN_MAX = 3'd7;

    // Input packing, lowest bit first
    localparam int IN_ARM_LSB    = 0;
    localparam int IN_PACKET_LSB = IN_ARM_LSB + ARM_BITS;
    localparam int IN_CHIP_LSB   = IN_PACKET_LSB + PACKET_BITS;
    localparam int IN_VALUE_LSB  = IN_CHIP_LSB + CHIP_BITS;
    localparam int IN_USED_W     = IN_VALUE_LSB + VALUE_BITS;
    localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

    // Output packing, lowest bit first
    localparam int OUT_GOOD_LSB   = 0;
    localparam int OUT_LOCKED_LSB = 1;
    localparam int OUT_MASK_LSB   = 2;
    localparam int OUT_DOM_LSB    = OUT_MASK_LSB + MASK_BITS;
    localparam int OUT_USED_W     = OUT_DOM_LSB + VALUE_BITS;
    localparam int OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 8;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CELL_LIMIT  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOCK_WINDOW = 1'd1;
    localparam logic [LIMIT_BITS-1:0]  CELL_LIMIT_RST  = 8'd48;
    localparam logic [WINDOW_BITS-1:0] LOCK_WINDOW_RST = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_MASK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic update;
        logic scan;
        logic mask;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic group_done;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

/* design/cidq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cidq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/cidq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidq_ctrl
// Sequencer: store clearing sweep, per-reading update, group scan, result load.
// ----------------------------------------------------------------------------
module cidq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  cidq_pkg::dp_status_t status,
    output cidq_pkg::dp_cmd_t    cmd
);

    cidq_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cidq_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            cidq_pkg::ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_last) begin
                    state_next = cidq_pkg::ST_IDLE;
                end
            end
            cidq_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = cidq_pkg::ST_UPDATE;
                end
            end
            cidq_pkg::ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = status.group_done ? cidq_pkg::ST_SCAN : cidq_pkg::ST_EMIT;
            end
            cidq_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_last) begin
                    state_next = cidq_pkg::ST_MASK;
                end
            end
            cidq_pkg::ST_MASK: begin
                cmd.mask   = 1'b1;
                state_next = cidq_pkg::ST_EMIT;
            end
            cidq_pkg::ST_EMIT: begin
                // hold the result until the output register is free
                cmd.emit = status.out_free;
                if (status.out_free) begin
                    state_next = cidq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cidq_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

/* design/cidq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidq_datapath
// Per-chip run store, group buffer, dominant value scan and output register.
// ----------------------------------------------------------------------------
module cidq_datapath #(
    parameter int ARMS       = cidq_pkg::ARMS_DEF,
    parameter int PACKETS    = cidq_pkg::PACKETS_DEF,
    parameter int CHIPS      = cidq_pkg::CHIPS_DEF,
    parameter int GROUP_SIZE = cidq_pkg::GROUP_SIZE_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  cidq_pkg::dp_cmd_t                     cmd,
    output cidq_pkg::dp_status_t                  status,
    input  logic [cidq_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                  s_tuser,
    input  logic                                  cfg_valid,
    input  logic [cidq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [cidq_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [cidq_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                  m_tuser
);

    localparam int DEPTH  = ARMS * PACKETS * CHIPS;
    localparam int AW     = $clog2(DEPTH);
    localparam int FW     = $clog2(GROUP_SIZE + 1);
    localparam int IW     = $clog2(GROUP_SIZE);
    localparam int MASK_N = (GROUP_SIZE < cidq_pkg::MASK_BITS) ? GROUP_SIZE
                                                              : cidq_pkg::MASK_BITS;
    localparam int VB     = cidq_pkg::VALUE_BITS;
    localparam int RB     = cidq_pkg::RUN_BITS;

    // ---------------- configuration registers ----------------
    logic [cidq_pkg::LIMIT_BITS-1:0]  cell_limit_reg;
    logic [cidq_pkg::WINDOW_BITS-1:0] lock_window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_limit_reg  <= cidq_pkg::CELL_LIMIT_RST;
            lock_window_reg <= cidq_pkg::LOCK_WINDOW_RST;
        end else if (cfg_valid) begin
            if (cfg_index == cidq_pkg::REG_CELL_LIMIT) begin
                cell_limit_reg <= cfg_wdata[cidq_pkg::LIMIT_BITS-1:0];
            end
            if (cfg_index == cidq_pkg::REG_LOCK_WINDOW) begin
                lock_window_reg <= cfg_wdata[cidq_pkg::WINDOW_BITS-1:0];
            end
        end
    end

    // ---------------- input decode ----------------
    logic [31:0]   arm_w, pkt_w, chip_w, addr_w;
    logic [AW-1:0] in_addr;
    logic          in_range;

    always_comb begin
        arm_w  = 32'(s_tdata[cidq_pkg::IN_ARM_LSB +: cidq_pkg::ARM_BITS]);
        pkt_w  = 32'(s_tdata[cidq_pkg::IN_PACKET_LSB +: cidq_pkg::PACKET_BITS]);
        chip_w = 32'(s_tdata[cidq_pkg::IN_CHIP_LSB +: cidq_pkg::CHIP_BITS]);
        addr_w = (arm_w * 32'(PACKETS) + pkt_w) * 32'(CHIPS) + chip_w;
        in_addr  = addr_w[AW-1:0];
        in_range = (arm_w < 32'(ARMS)) && (pkt_w < 32'(PACKETS)) && (chip_w < 32'(CHIPS));
    end

    logic [VB-1:0] val_reg;
    logic          start_reg;
    logic [AW-1:0] addr_reg;
    logic          range_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_reg   <= s_tdata[cidq_pkg::IN_VALUE_LSB +: VB];
            start_reg <= s_tuser;
            addr_reg  <= in_addr;
            range_reg <= in_range;
        end
    end

    // ---------------- per-chip store ----------------
    logic [AW-1:0] clr_cnt_reg;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [VB+RB-1:0] ram_wdata, ram_rdata;
    logic [RB-1:0] run_old, run_new;
    logic [VB-1:0] last_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_comb begin
        run_old  = ram_rdata[RB-1:0];
        last_val = ram_rdata[VB+RB-1:RB];
        if (run_old != '0 && last_val == val_reg) begin
            run_new = (run_old == cidq_pkg::RUN_MAX) ? cidq_pkg::RUN_MAX : run_old + 1'b1;
        end else begin
            run_new = RB'(1);
        end
        ram_we    = cmd.clear || (cmd.update && range_reg);
        ram_waddr = cmd.clear ? clr_cnt_reg : addr_reg;
        ram_wdata = cmd.clear ? '0 : {val_reg, run_new};
    end

    cidq_ram #(
        .WIDTH (VB + RB),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // ---------------- group buffer ----------------
    logic [VB-1:0] grp_reg [GROUP_SIZE];
    logic [FW-1:0] fill_reg, fill_base;
    logic          group_done;

    always_comb begin
        fill_base  = (start_reg || fill_reg >= FW'(GROUP_SIZE)) ? '0 : fill_reg;
        group_done = (fill_base == FW'(GROUP_SIZE - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cmd.update) begin
            fill_reg <= group_done ? '0 : fill_base + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            grp_reg[fill_base[IW-1:0]] <= val_reg;
        end
    end

    // ---------------- dominant value scan ----------------
    logic [IW-1:0]         idx_reg;
    logic [FW-1:0]         best_cnt_reg, cand_cnt;
    logic [VB-1:0]         best_val_reg, cand;
    logic [GROUP_SIZE-1:0] eq_vec;
    logic [cidq_pkg::MASK_BITS-1:0] mask_w;

    always_comb begin
        cand = grp_reg[idx_reg];
        for (int k = 0; k < GROUP_SIZE; k++) begin
            eq_vec[k] = (grp_reg[k] == cand);
        end
        cand_cnt = FW'($countones(eq_vec));
        mask_w = '0;
        for (int i = 0; i < MASK_N; i++) begin
            mask_w[i] = (grp_reg[i] == best_val_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            idx_reg      <= '0;
            best_cnt_reg <= '0;
        end else if (cmd.scan) begin
            idx_reg <= idx_reg + 1'b1;
            // strict compare keeps the earliest value on a tie
            if (cand_cnt > best_cnt_reg) begin
                best_cnt_reg <= cand_cnt;
                best_val_reg <= cand;
            end
        end
    end

    // ---------------- result assembly ----------------
    logic                           good_reg, locked_reg, mvalid_reg;
    logic [cidq_pkg::MASK_BITS-1:0] mask_reg;
    logic [VB-1:0]                  dom_reg;

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            good_reg   <= (val_reg != '0) && (val_reg < cell_limit_reg);
            locked_reg <= range_reg && (run_new >= lock_window_reg);
            mvalid_reg <= 1'b0;
            mask_reg   <= '0;
            dom_reg    <= '0;
        end else if (cmd.mask) begin
            mvalid_reg <= 1'b1;
            mask_reg   <= mask_w;
            dom_reg    <= best_val_reg;
        end
    end

    // ---------------- output register ----------------
    logic                            m_tvalid_reg;
    logic [cidq_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic                            m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= cidq_pkg::OUT_TDATA_W'({dom_reg, mask_reg, locked_reg, good_reg});
            m_tuser_reg <= mvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        status.clear_last = (clr_cnt_reg == AW'(DEPTH - 1));
        status.group_done = group_done;
        status.scan_last  = (idx_reg == IW'(GROUP_SIZE - 1));
        status.out_free   = !m_tvalid_reg || m_tready;
    end

endmodule

/* design/readout_cell_id_quality_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// readout_cell_id_quality_checker
// Flags each cell-ID reading as good and locked, and reports the dominant
// value and chip mask for each completed group within an event.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  s_*      | in        | s_tvalid/s_tready  | s_tdata: arm, packet, chip, value
//           |           |                    | s_tuser: event_start
//  m_*      | out       | m_tvalid/m_tready  | m_tdata: good, locked, mask, value
//           |           |                    | m_tuser: mask_valid
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
//  A reading is handled in order: accept, store read-modify-write, result load.
//  A reading that closes a group adds the dominant value scan and the mask load
//  before the result load; the scan tests one candidate per cycle through one
//  shared counter. After reset the store is cleared, one entry per cycle, over
//  all ARMS*PACKETS*CHIPS entries (768 by default); s_tready stays low meanwhile.
//  A result waits in the output register; the block accepts a new reading
//  while it waits, and stalls before loading the next result until it leaves.
// ----------------------------------------------------------------------------
module readout_cell_id_quality_checker #(
    parameter int ARMS       = cidq_pkg::ARMS_DEF,
    parameter int PACKETS    = cidq_pkg::PACKETS_DEF,
    parameter int CHIPS      = cidq_pkg::CHIPS_DEF,
    parameter int GROUP_SIZE = cidq_pkg::GROUP_SIZE_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] arm_sel, [3:1] packet_num, [9:4] chip_num, [17:10] cell_value
    input  logic [cidq_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [0] event_start
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] good_flag, [1] locked_flag, [13:2] dominance_mask, [21:14] dominant_value
    output logic [cidq_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // [0] mask_valid
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cidq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [cidq_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

    cidq_pkg::dp_cmd_t    cmd;
    cidq_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    cidq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cidq_datapath #(
        .ARMS       (ARMS),
        .PACKETS    (PACKETS),
        .CHIPS      (CHIPS),
        .GROUP_SIZE (GROUP_SIZE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* design/cidq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidq_checker
// Port-level checks of the cell-ID quality checker, bound to the top level.
// ----------------------------------------------------------------------------
module cidq_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [cidq_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tuser
);

    // no reading is taken while the store is being cleared
    a_clear_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    // one reading at a time: ready drops after each transfer
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready in the cycle after a transfer");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // without a completed group, mask and dominant value read zero
    a_no_group_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            m_tdata[cidq_pkg::OUT_TDATA_W-1:cidq_pkg::OUT_MASK_LSB] == '0)
        else $error("mask or dominant value set without a completed group");

endmodule

bind readout_cell_id_quality_checker cidq_checker u_cidq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
